/* hw/rtl/cbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbl_pkg
// shared sizes, types and helpers for the counter bank with lazy maximum
// ----------------------------------------------------------------------------
package cbl_pkg;

	localparam int MAX_COUNTERS = 1024;
	localparam int COUNT_WIDTH  = 32;
	localparam int ADDR_W       = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;

	localparam int CFG_W   = 11;
	localparam int INDEX_W = 12;
	localparam int VALUE_W = 32;

	localparam logic [CFG_W-1:0] ACTIVE_COUNT_RST = CFG_W'(1024);

	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// one accepted transaction on its way to the update stage
	typedef struct packed {
		logic              vld;
		logic              op;
		logic              ok;
		logic [ADDR_W-1:0] slot;
	} cbl_item_t;

	// low result bits of a counter, zero-extended where the counter is narrow
	function automatic logic [VALUE_W-1:0] to_value(input count_t c);
		logic [63:0] w;
		w = 64'(c);
		return w[VALUE_W-1:0];
	endfunction

endpackage

/* hw/rtl/cbl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbl_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module cbl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/cbl_clear.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbl_clear
// post-reset sweep that writes zero into every counter entry
// ----------------------------------------------------------------------------
module cbl_clear (
	input  logic                       clk,
	input  logic                       arst_n,
	output logic                       busy,
	output logic                       we,
	output logic [cbl_pkg::ADDR_W-1:0] waddr
);

	localparam logic ST_CLEAR = 1'b0;
	localparam logic ST_RUN   = 1'b1;

	localparam logic [cbl_pkg::ADDR_W-1:0] LAST_ADDR =
		cbl_pkg::ADDR_W'(cbl_pkg::MAX_COUNTERS - 1);

	logic                       state_q;
	logic [cbl_pkg::ADDR_W-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_RUN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign busy  = (state_q == ST_CLEAR);
	assign we    = busy;
	assign waddr = addr_q;

	// once the sweep is over it never starts again
	a_run_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> (state_q == ST_RUN))
		else $error("clear sweep restarted");

endmodule

/* hw/rtl/cbl_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbl_update
// read-modify-write stage: lift, increment, running max and floor
// ----------------------------------------------------------------------------
module cbl_update (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cbl_pkg::cbl_item_t         item_s1,
	input  cbl_pkg::count_t            rdata,
	output logic                       we,
	output logic [cbl_pkg::ADDR_W-1:0] waddr,
	output cbl_pkg::count_t            wdata,
	output logic                       done,
	output logic [cbl_pkg::VALUE_W-1:0] value,
	output logic                       index_valid
);

	cbl_pkg::count_t max_q;
	cbl_pkg::count_t floor_q;

	// last write, for the item whose ram read went out in the same cycle
	logic                       fwd_vld_q;
	logic [cbl_pkg::ADDR_W-1:0] fwd_slot_q;
	cbl_pkg::count_t            fwd_data_q;

	logic                        done_q;
	logic [cbl_pkg::VALUE_W-1:0] value_q;
	logic                        index_valid_q;

	cbl_pkg::count_t cur;
	cbl_pkg::count_t lifted;
	cbl_pkg::count_t bumped;
	logic            do_inc;
	logic            do_setall;

	always_comb begin
		cur       = (fwd_vld_q && fwd_slot_q == item_s1.slot) ? fwd_data_q : rdata;
		lifted    = (cur < floor_q) ? floor_q : cur;
		bumped    = (&lifted) ? lifted : lifted + 1'b1;
		do_inc    = item_s1.vld && item_s1.ok && item_s1.op == cbl_pkg::OP_EVENT;
		do_setall = item_s1.vld && !item_s1.ok && item_s1.op == cbl_pkg::OP_EVENT;
	end

	assign we    = do_inc;
	assign waddr = item_s1.slot;
	assign wdata = bumped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q         <= '0;
			floor_q       <= '0;
			fwd_vld_q     <= 1'b0;
			done_q        <= 1'b0;
			index_valid_q <= 1'b0;
		end else begin
			done_q        <= item_s1.vld;
			index_valid_q <= item_s1.ok;
			if (do_inc) begin
				fwd_vld_q <= 1'b1;
				if (bumped > max_q) begin
					max_q <= bumped;
				end
			end
			if (do_setall) begin
				floor_q <= max_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_inc) begin
			fwd_slot_q <= item_s1.slot;
			fwd_data_q <= bumped;
		end
		if (item_s1.vld) begin
			if (!item_s1.ok) begin
				value_q <= (item_s1.op == cbl_pkg::OP_EVENT) ?
					cbl_pkg::to_value(max_q) : '0;
			end else if (item_s1.op == cbl_pkg::OP_EVENT) begin
				value_q <= cbl_pkg::to_value(bumped);
			end else begin
				value_q <= cbl_pkg::to_value(lifted);
			end
		end
	end

	assign done        = done_q;
	assign value       = value_q;
	assign index_valid = index_valid_q;

	a_floor_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q <= max_q)
		else $error("floor above running max");

	a_max_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> max_q >= $past(max_q))
		else $error("running max decreased");

	a_bad_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(item_s1.vld && !item_s1.ok && item_s1.op == cbl_pkg::OP_READ)
		|=> (done_q && value_q == '0 && !index_valid_q))
		else $error("read of invalid index did not return zero");

endmodule

/* hw/rtl/counter_bank_with_lazy_max.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_bank_with_lazy_max
// bank of saturating counters with a lazy set-all-to-maximum operation
// ----------------------------------------------------------------------------
//
// channel   handshake             payload
// -------   ---------------------  ---------------------------
// command   start / busy           op, index
// result    done (one-cycle pulse) value, index_valid
// config    cfg_valid / cfg_ready  cfg_data (active_count)
//
// a command is registered into stage 1 along with its ram read, then into
// the done register that drives its result pulse; one command per cycle
// is sustained while busy is low, the ram is read once per command and
// written once per counter event, and a one-entry forward register covers a
// command that hits the counter written by the command just before it.
// after reset, busy stays high while the counter ram is swept to zero and
// config writes are taken meanwhile. the result side has no back-pressure.
// ----------------------------------------------------------------------------
module counter_bank_with_lazy_max (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [cbl_pkg::INDEX_W-1:0]  index,
	output logic                         done,
	output logic [cbl_pkg::VALUE_W-1:0]  value,
	output logic                         index_valid,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cbl_pkg::CFG_W-1:0]    cfg_data
);

	// active counter count, applies to commands accepted after the write
	logic [cbl_pkg::CFG_W-1:0] active_count_q;

	logic                       clr_busy;
	logic                       clr_we;
	logic [cbl_pkg::ADDR_W-1:0] clr_waddr;

	logic                       upd_we;
	logic [cbl_pkg::ADDR_W-1:0] upd_waddr;
	cbl_pkg::count_t            upd_wdata;

	logic                       accept;
	logic [31:0]                eff_count;
	logic                       idx_ok;
	logic [cbl_pkg::ADDR_W-1:0] rd_slot;
	cbl_pkg::count_t            rdata;

	logic                       ram_we;
	logic [cbl_pkg::ADDR_W-1:0] ram_waddr;
	cbl_pkg::count_t            ram_wdata;

	cbl_pkg::cbl_item_t         item_s1;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= cbl_pkg::ACTIVE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			active_count_q <= cfg_data;
		end
	end

	// command decode: effective count saturates at the bank size
	always_comb begin
		accept    = start && !busy;
		eff_count = (32'(active_count_q) > 32'(cbl_pkg::MAX_COUNTERS)) ?
			32'(cbl_pkg::MAX_COUNTERS) : 32'(active_count_q);
		idx_ok    = (index != '0) && (32'(index) <= eff_count);
		rd_slot   = cbl_pkg::ADDR_W'(index - 1'b1);
	end

	// stage 1 register: lines up with the ram's registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.vld <= accept;
			if (accept) begin
				item_s1.op   <= op;
				item_s1.ok   <= idx_ok;
				item_s1.slot <= rd_slot;
			end
		end
	end

	cbl_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.we     (clr_we),
		.waddr  (clr_waddr)
	);

	assign busy = clr_busy;

	// sweep owns the write port until it ends; no command runs meanwhile
	always_comb begin
		ram_we    = clr_we || upd_we;
		ram_waddr = clr_busy ? clr_waddr : upd_waddr;
		ram_wdata = clr_busy ? '0 : upd_wdata;
	end

	cbl_ram #(
		.WIDTH (cbl_pkg::COUNT_WIDTH),
		.DEPTH (cbl_pkg::MAX_COUNTERS),
		.AW    (cbl_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (rd_slot),
		.rdata (rdata)
	);

	cbl_update u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_s1     (item_s1),
		.rdata       (rdata),
		.we          (upd_we),
		.waddr       (upd_waddr),
		.wdata       (upd_wdata),
		.done        (done),
		.value       (value),
		.index_valid (index_valid)
	);

endmodule

/* tb/tb_counter_bank_with_lazy_max.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counter_bank_with_lazy_max
// self-checking bench for the counter bank with lazy set-all-to-maximum
// ----------------------------------------------------------------------------
// a short table of directed commands and config writes runs first, then
// random phases, each under its own active_count. every accepted command is
// run through a local model of the bank and its result is queued; every done
// pulse is checked field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module tb_counter_bank_with_lazy_max;
	import cbl_pkg::*;

	// cycles without any accepted transaction before the run is called dead;
	// the limit has to outlast the reset sweep, which keeps busy high
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 110;
	localparam int PLAN_ROWS   = 25;

	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	// one line of the directed table; typed = 1 means the result is given here
	typedef struct packed {
		row_kind_t          kind;
		logic [CFG_W-1:0]   cfg;
		logic               op;
		logic [INDEX_W-1:0] idx;
		logic               typed;
		logic [VALUE_W-1:0] val;
		logic               ok;
	} plan_row_t;

	typedef struct packed {
		logic [VALUE_W-1:0] val;
		logic               ok;
	} bank_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 op;
	logic [INDEX_W-1:0]   index;
	logic                 done;
	logic [VALUE_W-1:0]   value;
	logic                 index_valid;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;

	// result given by the directed table, travels alongside the command
	logic                 typed_chk;
	logic [VALUE_W-1:0]   typed_val;
	logic                 typed_ok;

	// local copy of the bank state
	count_t               bank [MAX_COUNTERS];
	count_t               peak;
	count_t               floor_lvl;
	logic [CFG_W-1:0]     act_cnt;

	bank_result_t         due_values [$];
	int                   err_count;
	int                   quiet_cycles;
	plan_row_t            plan [PLAN_ROWS];

	counter_bank_with_lazy_max DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.index       (index),
		.done        (done),
		.value       (value),
		.index_valid (index_valid),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// number of counters actually in use
	function automatic int unsigned live_count();
		return (act_cnt > MAX_COUNTERS) ? MAX_COUNTERS : act_cnt;
	endfunction

	// apply one command to the local bank and return what the block must answer
	function automatic bank_result_t apply_counter_cmd(input logic o,
			input logic [INDEX_W-1:0] i);
		bank_result_t r;
		count_t       c;
		r.ok = (i >= 1) && (i <= live_count());
		c = '0;
		if (r.ok) begin
			// lazy floor: a counter never reads below the last set-all level
			c = bank[i - 1];
			if (c < floor_lvl)
				c = floor_lvl;
			if (o == OP_EVENT) begin
				if (c != '1)
					c = c + 1'b1;
				bank[i - 1] = c;
				if (c > peak)
					peak = c;
			end
		end else if (o == OP_EVENT) begin
			// set-all-to-max: only the floor moves
			floor_lvl = peak;
			c = floor_lvl;
		end
		r.val = VALUE_W'(c);
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("%0t ns: %s got %0d, want %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// scoreboard side: expectations at command acceptance, checks on done
	always @(posedge clk) begin
		bank_result_t want;
		bank_result_t got;
		if (arst_n) begin
			quiet_cycles++;
			if (done) begin
				quiet_cycles = 0;
				got.val = value;
				got.ok = index_valid;
				if (due_values.size() == 0) begin
					flag_mismatch("result with nothing outstanding, value", got.val, '0);
				end else begin
					want = due_values.pop_front();
					if (got.val !== want.val)
						flag_mismatch("value", got.val, want.val);
					if (got.ok !== want.ok)
						flag_mismatch("index_valid", VALUE_W'(got.ok), VALUE_W'(want.ok));
				end
			end
			if (start && !busy) begin
				quiet_cycles = 0;
				want = apply_counter_cmd(op, index);
				if (typed_chk) begin
					want.val = typed_val;
					want.ok = typed_ok;
				end
				due_values.insert(due_values.size(), want);
			end
			if (cfg_valid && cfg_ready) begin
				quiet_cycles = 0;
				act_cnt = cfg_data;
			end
		end
	end

	// start stays high into the next command unless a gap is taken
	task automatic send_cmd(input logic o, input logic [INDEX_W-1:0] i, input logic t,
			input logic [VALUE_W-1:0] v, input logic k);
		start <= 1'b1;
		op <= o;
		index <= i;
		typed_chk <= t;
		typed_val <= v;
		typed_ok <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// sender drops start for a random gap, each extension drawn with odds of 28 in 100
	task automatic random_gap();
		int n;
		n = 0;
		while ($urandom_range(99) < 28)
			n++;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// let every outstanding result come back, then write active_count
	task automatic drain_and_write(input logic [CFG_W-1:0] v);
		start <= 1'b0;
		// the scoreboard has queued the last command by the falling edge
		@(negedge clk);
		while (due_values.size() != 0)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		// local count is updated before the next command is picked
		@(posedge clk);
	endtask

	// one random phase under the current active_count
	task automatic run_phase(input int n, input bit no_gaps);
		int unsigned  live;
		int unsigned  pick;
		logic [INDEX_W-1:0] last_idx;
		logic [INDEX_W-1:0] i;
		logic         o;
		live = live_count();
		last_idx = INDEX_W'(1);
		repeat (n) begin
			pick = $urandom_range(99);
			if (live == 0 && pick < 75)
				pick = 75 + $urandom_range(24);
			if (pick < 75) begin
				// valid counter traffic, biased to few counters and repeats
				o = (pick < 55) ? OP_EVENT : OP_READ;
				if ($urandom_range(99) < 35 && last_idx <= live)
					i = last_idx;
				else if ($urandom_range(1) == 1)
					i = INDEX_W'($urandom_range(1, (live < 8) ? live : 8));
				else
					i = INDEX_W'($urandom_range(1, live));
			end else if (pick < 87) begin
				// set-all-to-max
				o = OP_EVENT;
				i = ($urandom_range(1) == 1) ? '0 :
					INDEX_W'($urandom_range(live + 1, 4095));
			end else begin
				o = 1'($urandom_range(1));
				i = INDEX_W'($urandom_range(0, 4095));
			end
			last_idx = (i >= 1 && i <= live) ? i : last_idx;
			if (!no_gaps)
				random_gap();
			send_cmd(o, i, 1'b0, '0, 1'b0);
		end
	endtask

	// watchdog: no transaction for too long ends the run
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned cfg_plan [PHASES];
		err_count = 0;
		for (int s = 0; s < MAX_COUNTERS; s++)
			bank[s] = '0;
		peak = '0;
		floor_lvl = '0;
		act_cnt = ACTIVE_COUNT_RST;
		start <= 1'b0;
		op <= OP_EVENT;
		index <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		typed_chk <= 1'b0;
		typed_val <= '0;
		typed_ok <= 1'b0;
		arst_n <= 1'b0;

		// directed table, starting from the reset count of 1024
		plan = '{
			// fresh bank reads zero; index zero and the top index are out of range
			'{ROW_CMD, 11'd0,    OP_READ,  12'd1,    1'b1, 32'd0, 1'b1},
			'{ROW_CMD, 11'd0,    OP_READ,  12'd0,    1'b1, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_READ,  12'd4095, 1'b1, 32'd0, 1'b0},
			// repeated hits on one counter, then one on the top counter
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd1,    1'b1, 32'd1, 1'b1},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd1,    1'b1, 32'd2, 1'b1},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd1024, 1'b1, 32'd1, 1'b1},
			// set-all just past the last counter
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd1025, 1'b1, 32'd2, 1'b0},
			'{ROW_CMD, 11'd0,    OP_READ,  12'd500,  1'b1, 32'd2, 1'b1},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd500,  1'b0, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd1,    1'b0, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd4095, 1'b1, 32'd3, 1'b0},
			'{ROW_CMD, 11'd0,    OP_READ,  12'd1024, 1'b1, 32'd3, 1'b1},
			// zero counters in use: every event is set-all
			'{ROW_CFG, 11'd0,    OP_EVENT, 12'd0,    1'b0, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd1,    1'b1, 32'd3, 1'b0},
			'{ROW_CMD, 11'd0,    OP_READ,  12'd1,    1'b1, 32'd0, 1'b0},
			// count above the bank size is clipped to the bank size
			'{ROW_CFG, 11'd2047, OP_EVENT, 12'd0,    1'b0, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd1024, 1'b0, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_READ,  12'd1025, 1'b1, 32'd0, 1'b0},
			// single counter
			'{ROW_CFG, 11'd1,    OP_EVENT, 12'd0,    1'b0, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd1,    1'b0, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd2,    1'b1, 32'd4, 1'b0},
			'{ROW_CMD, 11'd0,    OP_READ,  12'd2,    1'b1, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_EVENT, 12'd1,    1'b0, 32'd0, 1'b0},
			'{ROW_CFG, 11'd1024, OP_EVENT, 12'd0,    1'b0, 32'd0, 1'b0},
			'{ROW_CMD, 11'd0,    OP_READ,  12'd2048, 1'b1, 32'd0, 1'b0}
		};

		// phase 2 runs with no sender gaps; phase 5 takes a random count
		cfg_plan[0] = 1024;
		cfg_plan[1] = 1;
		cfg_plan[2] = 2047;
		cfg_plan[3] = 0;
		cfg_plan[4] = 5;
		cfg_plan[5] = $urandom_range(1, 2047);
		cfg_plan[6] = 16;
		cfg_plan[7] = 1025;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				drain_and_write(plan[r].cfg);
			end else begin
				random_gap();
				send_cmd(plan[r].op, plan[r].idx, plan[r].typed, plan[r].val, plan[r].ok);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_and_write(CFG_W'(cfg_plan[p]));
			run_phase(PHASE_ITEMS, p == 2);
		end

		start <= 1'b0;
		while (due_values.size() != 0)
			@(negedge clk);
		// watch for stray result pulses
		repeat (8) @(posedge clk);
		if (err_count == 0 && due_values.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
